[rtl/mtc_pkg.sv]
// shared constants, types and helper functions for the multi screen text console
// no dependencies
package mtc_pkg;

	localparam int SCREENS = 3;
	localparam int COLS    = 80;
	localparam int ROWS    = 25;

	localparam int SCR_W  = 3;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CHR_W  = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = 16;

	localparam int CPS        = ROWS * COLS;
	localparam int CELLS      = SCREENS * CPS;
	localparam int COPY_CELLS = (ROWS - 1) * COLS;
	localparam int ADDR_W     = $clog2(CELLS);
	localparam int CNT_W      = $clog2(CPS);
	localparam int SIDX_W     = (SCREENS > 1) ? $clog2(SCREENS) : 1;

	localparam logic [CHR_W-1:0] CH_BLANK     = 8'h20;
	localparam logic [CHR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHR_W-1:0] CH_BACKSPACE = 8'h08;

	localparam logic [ATTR_W-1:0] START_COLOUR [8] = '{
		8'h02, 8'h03, 8'h0D, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07
	};

	typedef logic [SIDX_W-1:0] sidx_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [1:0] {
		FN_PUT    = 2'd0,
		FN_SWITCH = 2'd1,
		FN_COLOUR = 2'd2,
		FN_READ   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_RESP
	} state_t;

	typedef struct packed {
		func_t             func;
		logic [CHR_W-1:0]  char_code;
		logic [SCR_W-1:0]  screen_select;
		logic [ATTR_W-1:0] attribute;
		row_t              read_row;
		col_t              read_col;
	} item_t;

	typedef struct packed {
		logic              exec;
		func_t             func;
		logic [CHR_W-1:0]  char_code;
		logic [SCR_W-1:0]  screen_select;
		logic [ATTR_W-1:0] attribute;
	} cur_cmd_t;

	typedef struct packed {
		sidx_t             shown;
		row_t              row;
		col_t              col;
		logic [ATTR_W-1:0] colour;
	} cur_view_t;

	typedef struct packed {
		logic              we;
		addr_t             addr;
		logic [CELL_W-1:0] data;
		logic              scroll;
	} put_plan_t;

	function automatic logic [ATTR_W-1:0] start_colour(sidx_t s);
		return START_COLOUR[3'(s)];
	endfunction

	function automatic addr_t cell_addr(sidx_t s, row_t r, col_t c);
		return ADDR_W'(int'(s) * CPS + int'(r) * COLS + int'(c));
	endfunction

	function automatic addr_t base_addr(sidx_t s);
		return ADDR_W'(int'(s) * CPS);
	endfunction

endpackage

[rtl/mtc_req_if.sv]
// item channel into the console: valid/ready handshake with the command fields
// uses mtc_pkg for field widths
interface mtc_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                func;
	logic [mtc_pkg::CHR_W-1:0]  char_code;
	logic [mtc_pkg::SCR_W-1:0]  screen_select;
	logic [mtc_pkg::ATTR_W-1:0] attribute;
	logic [mtc_pkg::ROW_W-1:0]  read_row;
	logic [mtc_pkg::COL_W-1:0]  read_col;

	modport source (
		output valid, func, char_code, screen_select, attribute, read_row, read_col,
		input  ready
	);
	modport sink (
		input  valid, func, char_code, screen_select, attribute, read_row, read_col,
		output ready
	);
endinterface

[rtl/mtc_rsp_if.sv]
// result channel out of the console: valid/ready handshake with cursor and cell fields
// uses mtc_pkg for field widths
interface mtc_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [mtc_pkg::COL_W-1:0]  cursor_col;
	logic [mtc_pkg::ROW_W-1:0]  cursor_row;
	logic [mtc_pkg::SCR_W-1:0]  active_screen;
	logic [mtc_pkg::CELL_W-1:0] cell_value;

	modport source (
		output valid, cursor_col, cursor_row, active_screen, cell_value,
		input  ready
	);
	modport sink (
		input  valid, cursor_col, cursor_row, active_screen, cell_value,
		output ready
	);
endinterface

[rtl/mtc_ram.sv]
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module mtc_ram #(
	parameter int W = 16,
	parameter int D = 64,
	localparam int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];
	logic [W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

[rtl/mtc_cursor.sv]
// per screen cursor, colour and displayed screen registers, plus the put character
// cursor arithmetic; depends on mtc_pkg
module mtc_cursor (
	input  logic                clk,
	input  logic                arst_n,
	input  mtc_pkg::cur_cmd_t   cmd,
	output mtc_pkg::cur_view_t  view,
	output mtc_pkg::put_plan_t  plan
);

	mtc_pkg::row_t                row_q    [mtc_pkg::SCREENS];
	mtc_pkg::col_t                col_q    [mtc_pkg::SCREENS];
	logic [mtc_pkg::ATTR_W-1:0]   colour_q [mtc_pkg::SCREENS];
	mtc_pkg::sidx_t               shown_q;

	mtc_pkg::row_t nr, wr_r;
	mtc_pkg::col_t nc, wr_c;
	logic          adv_line;
	logic          wr_en;
	logic          scroll;
	logic [mtc_pkg::CHR_W-1:0] wr_chr;
	logic          put_go;
	logic          sel_ok;

	assign view.shown  = shown_q;
	assign view.row    = row_q[shown_q];
	assign view.col    = col_q[shown_q];
	assign view.colour = colour_q[shown_q];

	assign put_go = cmd.exec && (cmd.func == mtc_pkg::FN_PUT);
	assign sel_ok = ({1'b0, cmd.screen_select} < (mtc_pkg::SCR_W + 1)'(mtc_pkg::SCREENS))
		&& (cmd.screen_select != mtc_pkg::SCR_W'(shown_q));

	always_comb begin
		nr       = view.row;
		nc       = view.col;
		wr_r     = view.row;
		wr_c     = view.col;
		wr_chr   = cmd.char_code;
		wr_en    = 1'b0;
		adv_line = 1'b0;
		scroll   = 1'b0;
		case (cmd.char_code)
			mtc_pkg::CH_NEWLINE: begin
				adv_line = 1'b1;
			end
			mtc_pkg::CH_BACKSPACE: begin
				if (view.col == '0) begin
					if (view.row != '0) begin
						nr    = view.row - 1'b1;
						nc    = mtc_pkg::COL_W'(mtc_pkg::COLS - 1);
						wr_en = 1'b1;
					end
				end else begin
					nc    = view.col - 1'b1;
					wr_en = 1'b1;
				end
				wr_r   = nr;
				wr_c   = nc;
				wr_chr = mtc_pkg::CH_BLANK;
			end
			default: begin
				wr_en = 1'b1;
				if (view.col == mtc_pkg::COL_W'(mtc_pkg::COLS - 1)) begin
					adv_line = 1'b1;
				end else begin
					nc = view.col + 1'b1;
				end
			end
		endcase
		if (adv_line) begin
			nc = '0;
			if (view.row == mtc_pkg::ROW_W'(mtc_pkg::ROWS - 1)) begin
				scroll = 1'b1;
			end else begin
				nr = view.row + 1'b1;
			end
		end
	end

	assign plan.we     = put_go && wr_en;
	assign plan.addr   = mtc_pkg::cell_addr(shown_q, wr_r, wr_c);
	assign plan.data   = {view.colour, wr_chr};
	assign plan.scroll = put_go && scroll;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mtc_pkg::SCREENS; i++) begin
				row_q[i]    <= '0;
				col_q[i]    <= '0;
				colour_q[i] <= mtc_pkg::start_colour(mtc_pkg::SIDX_W'(i));
			end
			shown_q <= '0;
		end else if (cmd.exec) begin
			case (cmd.func)
				mtc_pkg::FN_PUT: begin
					row_q[shown_q] <= nr;
					col_q[shown_q] <= nc;
				end
				mtc_pkg::FN_SWITCH: begin
					if (sel_ok) begin
						shown_q <= mtc_pkg::SIDX_W'(cmd.screen_select);
					end
				end
				mtc_pkg::FN_COLOUR: begin
					colour_q[shown_q] <= cmd.attribute;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/multi_screen_text_console_unit.sv]
// top level of the multi screen text console: sequencer, cell ram sweep, output register
// depends on mtc_pkg, mtc_req_if, mtc_rsp_if, mtc_ram, mtc_cursor
// the taken item is registered, executed in ST_EXEC, and its result registered in ST_RESP
// a scroll adds a ST_SCROLL sweep before ST_RESP; the next item is taken after the result loads
// the scroll walks the screen once through the single read and single write port of the ram
// reset: a clearing pass fills the ram with blanks in each screen's start colour, ready low
module multi_screen_text_console_unit (
	input  logic      clk,
	input  logic      arst_n,
	mtc_req_if.sink   req,
	mtc_rsp_if.source rsp
);

	mtc_pkg::state_t state_q, state_d;
	mtc_pkg::item_t  item_q;
	mtc_pkg::cnt_t   cnt_q;
	mtc_pkg::sidx_t  scr_q;

	logic                       sw_v_s1;
	mtc_pkg::addr_t             sw_addr_s1;
	logic                       sw_blank_s1;
	logic [mtc_pkg::ATTR_W-1:0] sw_colour_s1;

	logic rd_ok_q;
	logic out_valid_q;
	mtc_pkg::col_t              out_col_q;
	mtc_pkg::row_t              out_row_q;
	logic [mtc_pkg::SCR_W-1:0]  out_scr_q;
	logic [mtc_pkg::CELL_W-1:0] out_cell_q;

	logic                       ram_we, ram_re;
	mtc_pkg::addr_t             ram_waddr, ram_raddr;
	logic [mtc_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

	mtc_pkg::cur_cmd_t  cmd;
	mtc_pkg::cur_view_t view;
	mtc_pkg::put_plan_t plan;

	logic sweep_go, sweep_copy, sweep_last, read_hit, out_load, exec;
	logic [mtc_pkg::ATTR_W-1:0] sweep_colour;

	assign cmd.exec          = exec;
	assign cmd.func          = item_q.func;
	assign cmd.char_code     = item_q.char_code;
	assign cmd.screen_select = item_q.screen_select;
	assign cmd.attribute     = item_q.attribute;

	mtc_cursor u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.view   (view),
		.plan   (plan)
	);

	mtc_ram #(
		.W (mtc_pkg::CELL_W),
		.D (mtc_pkg::CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign sweep_last = (cnt_q == mtc_pkg::CNT_W'(mtc_pkg::CPS - 1));
	assign read_hit   = (item_q.func == mtc_pkg::FN_READ)
		&& (int'(item_q.read_row) < mtc_pkg::ROWS)
		&& (int'(item_q.read_col) < mtc_pkg::COLS);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mtc_pkg::ST_CLEAR: begin
				if (sweep_last && scr_q == mtc_pkg::SIDX_W'(mtc_pkg::SCREENS - 1)) begin
					state_d = mtc_pkg::ST_IDLE;
				end
			end
			mtc_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = mtc_pkg::ST_EXEC;
				end
			end
			mtc_pkg::ST_EXEC: begin
				state_d = plan.scroll ? mtc_pkg::ST_SCROLL : mtc_pkg::ST_RESP;
			end
			mtc_pkg::ST_SCROLL: begin
				if (sweep_last) begin
					state_d = mtc_pkg::ST_RESP;
				end
			end
			mtc_pkg::ST_RESP: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = mtc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mtc_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready    = 1'b0;
		exec         = 1'b0;
		sweep_go     = 1'b0;
		sweep_copy   = 1'b0;
		out_load     = 1'b0;
		sweep_colour = view.colour;
		case (state_q)
			mtc_pkg::ST_CLEAR: begin
				sweep_go     = 1'b1;
				sweep_colour = mtc_pkg::start_colour(scr_q);
			end
			mtc_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			mtc_pkg::ST_EXEC: begin
				exec = 1'b1;
			end
			mtc_pkg::ST_SCROLL: begin
				sweep_go   = 1'b1;
				sweep_copy = (int'(cnt_q) < mtc_pkg::COPY_CELLS);
			end
			mtc_pkg::ST_RESP: begin
				out_load = !out_valid_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	assign ram_re    = sweep_copy || (exec && read_hit);
	assign ram_raddr = sweep_copy
		? mtc_pkg::ADDR_W'(mtc_pkg::base_addr(scr_q) + mtc_pkg::ADDR_W'(cnt_q)
			+ mtc_pkg::ADDR_W'(mtc_pkg::COLS))
		: mtc_pkg::cell_addr(view.shown, item_q.read_row, item_q.read_col);

	assign ram_we    = sw_v_s1 || plan.we;
	assign ram_waddr = sw_v_s1 ? sw_addr_s1 : plan.addr;
	assign ram_wdata = sw_v_s1
		? (sw_blank_s1 ? {sw_colour_s1, mtc_pkg::CH_BLANK} : ram_rdata)
		: plan.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mtc_pkg::ST_CLEAR;
			cnt_q       <= '0;
			scr_q       <= '0;
			sw_v_s1     <= 1'b0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sw_v_s1 <= sweep_go;
			if (sweep_go) begin
				if (sweep_last) begin
					cnt_q <= '0;
					if (state_q == mtc_pkg::ST_CLEAR) begin
						scr_q <= scr_q + 1'b1;
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (exec) begin
				cnt_q   <= '0;
				scr_q   <= view.shown;
				rd_ok_q <= read_hit;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_q.func          <= mtc_pkg::func_t'(req.func);
			item_q.char_code     <= req.char_code;
			item_q.screen_select <= req.screen_select;
			item_q.attribute     <= req.attribute;
			item_q.read_row      <= req.read_row;
			item_q.read_col      <= req.read_col;
		end
		if (sweep_go) begin
			sw_addr_s1   <= mtc_pkg::ADDR_W'(mtc_pkg::base_addr(scr_q)
				+ mtc_pkg::ADDR_W'(cnt_q));
			sw_blank_s1  <= !sweep_copy;
			sw_colour_s1 <= sweep_colour;
		end
		if (out_load) begin
			out_col_q  <= view.col;
			out_row_q  <= view.row;
			out_scr_q  <= mtc_pkg::SCR_W'(view.shown);
			out_cell_q <= rd_ok_q ? ram_rdata : '0;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.cursor_col    = out_col_q;
	assign rsp.cursor_row    = out_row_q;
	assign rsp.active_screen = out_scr_q;
	assign rsp.cell_value    = out_cell_q;

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(sw_v_s1 && plan.we))
		else $error("sweep and item write the cell ram together");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (int'(rsp.cursor_col) < mtc_pkg::COLS
			&& int'(rsp.cursor_row) < mtc_pkg::ROWS))
		else $error("cursor out of screen");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mtc_pkg::ST_RESP && $past(state_q) == mtc_pkg::ST_SCROLL)
		|-> (view.row == mtc_pkg::ROW_W'(mtc_pkg::ROWS - 1)))
		else $error("cursor not on bottom row after scroll");

endmodule

[tb/sv/tb_multi_screen_text_console_unit.sv]
// self-checking testbench for multi_screen_text_console_unit: directed table, then random bursts
// depends on mtc_pkg, mtc_req_if, mtc_rsp_if and the console rtl
// results are checked in order against fixed table rows or a shadow copy of every screen kept in the testbench
module tb_multi_screen_text_console_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import mtc_pkg::*;

	localparam int RANDOM_ITEMS = 650;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam longint LIMIT = longint'(CELLS) + longint'(RANDOM_ITEMS + 120) *
		longint'(CPS + 3 + 16) * 64'd4 + longint'(HOLD_CYCLES);

	typedef struct packed {
		col_t              col;
		row_t              row;
		logic [SCR_W-1:0]  scr;
		logic [CELL_W-1:0] cell_val;
	} status_t;

	typedef struct {
		func_t             func;
		logic [CHR_W-1:0]  chr;
		logic [SCR_W-1:0]  sel;
		logic [ATTR_W-1:0] attr;
		row_t              rrow;
		col_t              rcol;
		bit                fixed;
		col_t              col;
		row_t              row;
		logic [SCR_W-1:0]  scr;
		logic [CELL_W-1:0] cell_val;
	} step_t;

	// fixed rows carry the status read straight off the spec, the rest use the shadow
	step_t directed_steps [26] = '{
		'{FN_READ,   8'h00, 3'd0, 8'h00, 5'd0,  7'd0,   1, 7'd0,  5'd0, 3'd0, 16'h0220},
		'{FN_READ,   8'h00, 3'd0, 8'h00, 5'd24, 7'd79,  1, 7'd0,  5'd0, 3'd0, 16'h0220},
		'{FN_READ,   8'hFF, 3'd7, 8'hFF, 5'd31, 7'd127, 1, 7'd0,  5'd0, 3'd0, 16'h0000},
		'{FN_READ,   8'h00, 3'd0, 8'h00, 5'd25, 7'd0,   1, 7'd0,  5'd0, 3'd0, 16'h0000},
		'{FN_READ,   8'h00, 3'd0, 8'h00, 5'd0,  7'd80,  1, 7'd0,  5'd0, 3'd0, 16'h0000},
		'{FN_PUT,    8'h08, 3'd0, 8'h00, 5'd0,  7'd0,   1, 7'd0,  5'd0, 3'd0, 16'h0000},
		'{FN_PUT,    8'h41, 3'd0, 8'h00, 5'd0,  7'd0,   1, 7'd1,  5'd0, 3'd0, 16'h0000},
		'{FN_PUT,    8'hFF, 3'd0, 8'h00, 5'd0,  7'd0,   1, 7'd2,  5'd0, 3'd0, 16'h0000},
		'{FN_PUT,    8'h00, 3'd0, 8'h00, 5'd0,  7'd0,   1, 7'd3,  5'd0, 3'd0, 16'h0000},
		'{FN_READ,   8'h00, 3'd0, 8'h00, 5'd0,  7'd1,   1, 7'd3,  5'd0, 3'd0, 16'h02FF},
		'{FN_PUT,    8'h08, 3'd0, 8'h00, 5'd0,  7'd0,   1, 7'd2,  5'd0, 3'd0, 16'h0000},
		'{FN_READ,   8'h00, 3'd0, 8'h00, 5'd0,  7'd2,   1, 7'd2,  5'd0, 3'd0, 16'h0220},
		'{FN_COLOUR, 8'h00, 3'd0, 8'hFF, 5'd0,  7'd0,   1, 7'd2,  5'd0, 3'd0, 16'h0000},
		'{FN_PUT,    8'h0A, 3'd0, 8'h00, 5'd0,  7'd0,   1, 7'd0,  5'd1, 3'd0, 16'h0000},
		'{FN_PUT,    8'h08, 3'd0, 8'h00, 5'd0,  7'd0,   1, 7'd79, 5'd0, 3'd0, 16'h0000},
		'{FN_READ,   8'h00, 3'd0, 8'h00, 5'd0,  7'd79,  1, 7'd79, 5'd0, 3'd0, 16'hFF20},
		'{FN_SWITCH, 8'h00, 3'd7, 8'h00, 5'd0,  7'd0,   1, 7'd79, 5'd0, 3'd0, 16'h0000},
		'{FN_SWITCH, 8'h00, 3'd0, 8'h00, 5'd0,  7'd0,   1, 7'd79, 5'd0, 3'd0, 16'h0000},
		'{FN_SWITCH, 8'h00, 3'd2, 8'h00, 5'd0,  7'd0,   1, 7'd0,  5'd0, 3'd2, 16'h0000},
		'{FN_READ,   8'h00, 3'd0, 8'h00, 5'd0,  7'd0,   1, 7'd0,  5'd0, 3'd2, 16'h0D20},
		'{FN_COLOUR, 8'h00, 3'd0, 8'h00, 5'd0,  7'd0,   0, 7'd0,  5'd0, 3'd0, 16'h0000},
		'{FN_PUT,    8'h7A, 3'd0, 8'h00, 5'd0,  7'd0,   0, 7'd0,  5'd0, 3'd0, 16'h0000},
		'{FN_SWITCH, 8'h00, 3'd1, 8'h00, 5'd0,  7'd0,   1, 7'd0,  5'd0, 3'd1, 16'h0000},
		'{FN_READ,   8'h00, 3'd0, 8'h00, 5'd12, 7'd40,  1, 7'd0,  5'd0, 3'd1, 16'h0320},
		'{FN_SWITCH, 8'h00, 3'd0, 8'h00, 5'd0,  7'd0,   1, 7'd79, 5'd0, 3'd0, 16'h0000},
		'{FN_PUT,    8'h71, 3'd0, 8'h00, 5'd0,  7'd0,   1, 7'd0,  5'd1, 3'd0, 16'h0000}
	};

	logic clk = 1'b0;
	logic arst_n;

	mtc_req_if req_ch ();
	mtc_rsp_if rsp_ch ();

	multi_screen_text_console_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #4 clk = ~clk;

	logic [CELL_W-1:0] shadow_cells [SCREENS][ROWS][COLS];
	int                shadow_row [SCREENS];
	int                shadow_col [SCREENS];
	logic [ATTR_W-1:0] shadow_colour [SCREENS];
	int                shadow_shown;

	status_t owed_status [$];
	int      mismatches = 0;
	longint  cycles = 0;
	bit      calm = 1'b0;
	bit      hold_req = 1'b0;

	function automatic void clear_shadow();
		logic [ATTR_W-1:0] boot_colour [4] = '{8'h02, 8'h03, 8'h0D, 8'h07};
		for (int s = 0; s < SCREENS; s++) begin
			shadow_row[s] = 0;
			shadow_col[s] = 0;
			shadow_colour[s] = boot_colour[(s < 3) ? s : 3];
			for (int r = 0; r < ROWS; r++)
				for (int c = 0; c < COLS; c++)
					shadow_cells[s][r][c] = {boot_colour[(s < 3) ? s : 3], CH_BLANK};
		end
		shadow_shown = 0;
	endfunction

	function automatic void line_feed(int s);
		shadow_col[s] = 0;
		shadow_row[s]++;
		if (shadow_row[s] >= ROWS) begin
			for (int r = 0; r < ROWS - 1; r++)
				for (int c = 0; c < COLS; c++)
					shadow_cells[s][r][c] = shadow_cells[s][r+1][c];
			for (int c = 0; c < COLS; c++)
				shadow_cells[s][ROWS-1][c] = {shadow_colour[s], CH_BLANK};
			shadow_row[s] = ROWS - 1;
		end
	endfunction

	task automatic run_console_item(input item_t it, output status_t st);
		int s;
		logic [CELL_W-1:0] cell_val;
		s = shadow_shown;
		cell_val = '0;
		case (it.func)
			FN_PUT: begin
				if (it.char_code == CH_NEWLINE) begin
					line_feed(s);
				end else if (it.char_code == CH_BACKSPACE) begin
					if (shadow_col[s] != 0 || shadow_row[s] != 0) begin
						if (shadow_col[s] == 0) begin
							shadow_row[s]--;
							shadow_col[s] = COLS - 1;
						end else begin
							shadow_col[s]--;
						end
						shadow_cells[s][shadow_row[s]][shadow_col[s]] = {shadow_colour[s], CH_BLANK};
					end
				end else begin
					shadow_cells[s][shadow_row[s]][shadow_col[s]] = {shadow_colour[s], it.char_code};
					shadow_col[s]++;
					if (shadow_col[s] >= COLS)
						line_feed(s);
				end
			end
			FN_SWITCH: begin
				if (it.screen_select < SCREENS && it.screen_select != shadow_shown)
					shadow_shown = it.screen_select;
			end
			FN_COLOUR: shadow_colour[s] = it.attribute;
			default: begin
				if (it.read_row < ROWS && it.read_col < COLS)
					cell_val = shadow_cells[s][it.read_row][it.read_col];
			end
		endcase
		s = shadow_shown;
		st.col  = col_t'(shadow_col[s]);
		st.row  = row_t'(shadow_row[s]);
		st.scr  = SCR_W'(s);
		st.cell_val = cell_val;
	endtask

	task automatic offer_item(input item_t it, input bit fixed, input status_t want);
		status_t st;
		while (!calm && $urandom_range(99) < 23) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.func          <= it.func;
		req_ch.char_code     <= it.char_code;
		req_ch.screen_select <= it.screen_select;
		req_ch.attribute     <= it.attribute;
		req_ch.read_row      <= it.read_row;
		req_ch.read_col      <= it.read_col;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		run_console_item(it, st);
		owed_status.push_back(fixed ? want : st);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		mismatches++;
	endtask

	function automatic item_t noise_item();
		item_t it;
		it.func          = func_t'($urandom_range(3));
		it.char_code     = CHR_W'($urandom);
		it.screen_select = SCR_W'($urandom);
		it.attribute     = ATTR_W'($urandom);
		it.read_row      = row_t'($urandom);
		it.read_col      = col_t'($urandom);
		return it;
	endfunction

	// receiver: random stalls, a calm stretch, and one long hold-off
	initial begin
		int held;
		held = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				held = HOLD_CYCLES;
			end
			if (held > 0) begin
				held--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(99) >= 23);
			end
		end
	end

	always @(posedge clk) begin
		status_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (owed_status.size() == 0) begin
				report_mismatch("item with nothing pending", int'(rsp_ch.cell_value), 0);
			end else begin
				want = owed_status.pop_front();
				if (rsp_ch.cursor_col !== want.col)
					report_mismatch("cursor_col", int'(rsp_ch.cursor_col), int'(want.col));
				if (rsp_ch.cursor_row !== want.row)
					report_mismatch("cursor_row", int'(rsp_ch.cursor_row), int'(want.row));
				if (rsp_ch.active_screen !== want.scr)
					report_mismatch("active_screen", int'(rsp_ch.active_screen), int'(want.scr));
				if (rsp_ch.cell_value !== want.cell_val)
					report_mismatch("cell_value", int'(rsp_ch.cell_value), int'(want.cell_val));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		item_t   it;
		status_t want;
		int      counted;
		int      pick;
		int      len;
		int      s;
		bit      held_once;
		bit      paused_once;

		counted = 0;
		held_once = 1'b0;
		paused_once = 1'b0;
		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.func          <= '0;
		req_ch.char_code     <= '0;
		req_ch.screen_select <= '0;
		req_ch.attribute     <= '0;
		req_ch.read_row      <= '0;
		req_ch.read_col      <= '0;
		clear_shadow();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_steps[i]) begin
			it.func          = directed_steps[i].func;
			it.char_code     = directed_steps[i].chr;
			it.screen_select = directed_steps[i].sel;
			it.attribute     = directed_steps[i].attr;
			it.read_row      = directed_steps[i].rrow;
			it.read_col      = directed_steps[i].rcol;
			want.col  = directed_steps[i].col;
			want.row  = directed_steps[i].row;
			want.scr  = directed_steps[i].scr;
			want.cell_val = directed_steps[i].cell_val;
			offer_item(it, directed_steps[i].fixed, want);
		end

		while (counted < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 35)
				len = $urandom_range(40, 1);
			else if (pick < 50)
				len = $urandom_range(30, 1);
			else if (pick < 58)
				len = $urandom_range(12, 1);
			else if (pick < 75)
				len = 1;
			else if (pick < 92)
				len = $urandom_range(6, 1);
			else
				len = $urandom_range(4, 1);
			for (int k = 0; k < len; k++) begin
				it = noise_item();
				s = shadow_shown;
				if (pick < 35) begin
					it.func = FN_PUT;
					if ($urandom_range(15) != 0)
						it.char_code = CHR_W'($urandom_range(8'h7E, CH_BLANK));
				end else if (pick < 50) begin
					it.func = FN_PUT;
					it.char_code = CH_NEWLINE;
				end else if (pick < 58) begin
					it.func = FN_PUT;
					it.char_code = CH_BACKSPACE;
				end else if (pick < 68) begin
					it.func = FN_SWITCH;
					if ($urandom_range(3) != 0)
						it.screen_select = SCR_W'($urandom_range(SCREENS - 1));
				end else if (pick < 75) begin
					it.func = FN_COLOUR;
				end else if (pick < 92) begin
					it.func = FN_READ;
					if ($urandom_range(7) == 0) begin
					end else if ($urandom_range(1) == 0) begin
						it.read_row = row_t'((shadow_row[s] > 0 && $urandom_range(1) == 1) ?
							shadow_row[s] - 1 : shadow_row[s]);
						it.read_col = col_t'($urandom_range(COLS - 1));
					end else begin
						it.read_row = row_t'($urandom_range(ROWS - 1));
						it.read_col = col_t'($urandom_range(COLS - 1));
					end
				end
				if (!(it.func == FN_SWITCH &&
						(it.screen_select >= SCREENS || it.screen_select == shadow_shown)))
					counted++;
				calm = (counted >= 150 && counted < 250);
				if (counted >= 300 && !held_once) begin
					held_once = 1'b1;
					hold_req = 1'b1;
				end
				if (counted >= 450 && !paused_once) begin
					paused_once = 1'b1;
					req_ch.valid <= 1'b0;
					while (owed_status.size() != 0)
						@(posedge clk);
				end
				want = '0;
				offer_item(it, 1'b0, want);
			end
		end

		req_ch.valid <= 1'b0;
		while (owed_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
